[hdl/bpcm_pkg.sv]
// ----------------------------------------------------------------------------
// Battery presence cutoff monitor package
// Beat types, configuration layout, register indexes and percent scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package bpcm_pkg;

    localparam int unsigned MV_W   = 16;
    localparam int unsigned RUN_W  = 8;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned CIDX_W = 3;
    localparam int unsigned CDAT_W = 16;

    localparam logic [CIDX_W-1:0] CFG_ABSENT_THR = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_HYST       = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_DEBOUNCE   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_CUTOFF     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_LOW_WARN   = 3'd4;

    localparam logic [MV_W-1:0]  RST_ABSENT_THR = 16'd3000;
    localparam logic [MV_W-1:0]  RST_HYST       = 16'd500;
    localparam logic [RUN_W-1:0] RST_DEBOUNCE   = 8'd5;
    localparam logic [MV_W-1:0]  RST_CUTOFF     = 16'd6400;
    localparam logic [MV_W-1:0]  RST_LOW_WARN   = 16'd6800;

    // floor((mv - 6000) * 100 / 2400) == floor((mv - 6000) / 24)
    localparam int unsigned PctBase = 6000;
    localparam int unsigned PctSpan = 2400;
    localparam int unsigned PctFull = 100;
    localparam int unsigned PctStep = PctSpan / PctFull;
    localparam int unsigned PctCap  = PctBase + PctStep * (PctFull + 1);

    localparam logic [MV_W-1:0]  PCT_BASE_MV = MV_W'(PctBase);
    localparam logic [MV_W-1:0]  PCT_CAP_MV  = MV_W'(PctCap);
    localparam logic [PCT_W-1:0] PCT_FULL    = PCT_W'(PctFull);
    // divide by 3 after >>3: e * 171 >> 9 is exact for e < 512
    localparam logic [8:0]       PCT_RECIP   = 9'd171;

    typedef struct packed {
        logic [MV_W-1:0] sample_mv;
        logic            cutoff_latched;
    } t_in_beat;

    typedef struct packed {
        logic [MV_W-1:0]  echo_mv;
        logic             present;
        logic             low_battery;
        logic [PCT_W-1:0] percent;
        logic             set_cutoff_now;
        logic             clear_latch_now;
    } t_out_beat;

    typedef struct packed {
        logic [MV_W-1:0]  absent_thr;
        logic [MV_W-1:0]  hyst;
        logic [RUN_W-1:0] debounce;
        logic [MV_W-1:0]  cutoff;
        logic [MV_W-1:0]  low_warn;
    } t_cfg;

    typedef struct packed {
        logic present;
        logic clear_now;
    } t_pres_status;

    function automatic logic [PCT_W-1:0] pct_of(input logic [MV_W-1:0] mv);
        logic [MV_W-1:0] d;
        logic [8:0]      e;
        logic [17:0]     prod;
        d    = mv - PCT_BASE_MV;
        e    = d[11:3];
        prod = 18'(e) * 18'(PCT_RECIP);
        if (mv <= PCT_BASE_MV) begin
            return '0;
        end else if (mv >= PCT_CAP_MV) begin
            return PCT_FULL;
        end else begin
            return prod[15:9];
        end
    endfunction

endpackage

`default_nettype wire

[hdl/bpcm_presence.sv]
// ----------------------------------------------------------------------------
// Battery presence debounce
// Saturating below/above run counters with a dead band; absent flag state.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcm_presence (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [15:0]           i_mv,
    input  wire logic                  i_latched,
    input  wire bpcm_pkg::t_cfg        i_cfg,
    output bpcm_pkg::t_pres_status     o_status
);
    import bpcm_pkg::*;

    logic             r_absent;
    logic [RUN_W-1:0] r_below_run;
    logic [RUN_W-1:0] r_above_run;
    logic             n_absent;
    logic [RUN_W-1:0] n_below_run;
    logic [RUN_W-1:0] n_above_run;
    logic             below;
    logic             above;
    logic [MV_W:0]    band_top;
    logic             clear_now;

    assign band_top = {1'b0, i_cfg.absent_thr} + {1'b0, i_cfg.hyst};
    assign below    = i_mv < i_cfg.absent_thr;
    assign above    = {1'b0, i_mv} > band_top;

    always_comb begin
        n_absent    = r_absent;
        n_below_run = r_below_run;
        n_above_run = r_above_run;
        clear_now   = 1'b0;
        priority if (below) begin
            n_above_run = '0;
            if (r_below_run < i_cfg.debounce) begin
                n_below_run = r_below_run + RUN_W'(1);
            end
            if (n_below_run >= i_cfg.debounce && !r_absent) begin
                n_absent  = 1'b1;
                clear_now = i_latched;
            end
        end else if (above) begin
            n_below_run = '0;
            if (r_above_run < i_cfg.debounce) begin
                n_above_run = r_above_run + RUN_W'(1);
            end
            if (n_above_run >= i_cfg.debounce) begin
                n_absent = 1'b0;
            end
        end else begin
            n_absent = r_absent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_absent    <= 1'b0;
            r_below_run <= '0;
            r_above_run <= '0;
        end else if (i_step) begin
            r_absent    <= n_absent;
            r_below_run <= n_below_run;
            r_above_run <= n_above_run;
        end
    end

    assign o_status.present   = !n_absent;
    assign o_status.clear_now = clear_now;

`ifndef SYNTHESIS
    a_clear_enters_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && clear_now |=> r_absent)
        else $error("clear request without entering absent");
    a_counters_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_below_run != '0 && r_above_run != '0))
        else $error("both run counters nonzero");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_absent) && $stable(r_below_run) && $stable(r_above_run))
        else $error("presence state moved without a step");
`endif

endmodule

`default_nettype wire

[hdl/battery_presence_cutoff_monitor_core.sv]
// Flow: an accepted beat is held in the input register, then moves to the result register when it advances.
// Throughput: one beat per cycle unless output stalls; input register, one pass of compare logic, result register.
// Result register frees as the sink takes a beat, so input accept continues under a full output.
// Reset: config returns to defaults, battery counts present, run counters zero, pipe empty.
// ----------------------------------------------------------------------------
// Battery presence cutoff monitor core
// Debounced presence, cutoff and clear requests, low warning and charge percent.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_presence_cutoff_monitor_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_idx,
    input  wire logic [15:0]           i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire bpcm_pkg::t_in_beat    i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output bpcm_pkg::t_out_beat        o_out_data,
    input  wire logic                  i_out_stall
);
    import bpcm_pkg::*;

    t_cfg         r_cfg;
    logic         r_s1_valid;
    t_in_beat     r_s1_data;
    logic         r_out_valid;
    t_out_beat    r_out_data;
    t_out_beat    n_out_data;
    t_pres_status pres;
    logic         advance;
    logic         step;

    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.absent_thr <= RST_ABSENT_THR;
            r_cfg.hyst       <= RST_HYST;
            r_cfg.debounce   <= RST_DEBOUNCE;
            r_cfg.cutoff     <= RST_CUTOFF;
            r_cfg.low_warn   <= RST_LOW_WARN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ABSENT_THR: r_cfg.absent_thr <= i_cfg_data;
                CFG_HYST:       r_cfg.hyst       <= i_cfg_data;
                CFG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_data[RUN_W-1:0];
                CFG_CUTOFF:     r_cfg.cutoff     <= i_cfg_data;
                CFG_LOW_WARN:   r_cfg.low_warn   <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    bpcm_presence u_presence (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_mv      (r_s1_data.sample_mv),
        .i_latched (r_s1_data.cutoff_latched),
        .i_cfg     (r_cfg),
        .o_status  (pres)
    );

    always_comb begin
        n_out_data.echo_mv         = r_s1_data.sample_mv;
        n_out_data.present         = pres.present;
        n_out_data.low_battery     = pres.present
                                     && (r_s1_data.sample_mv < r_cfg.low_warn);
        n_out_data.percent         = pct_of(r_s1_data.sample_mv);
        n_out_data.set_cutoff_now  = pres.present
                                     && (r_s1_data.sample_mv < r_cfg.cutoff)
                                     && !r_s1_data.cutoff_latched;
        n_out_data.clear_latch_now = pres.clear_now;
    end

    // advance the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_data <= i_in_data;
        end
    end

    // advance the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.percent <= PCT_FULL)
        else $error("percent above full scale");
    a_requests_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.set_cutoff_now || o_out_data.low_battery)
            |-> o_out_data.present && !o_out_data.clear_latch_now)
        else $error("present-only flag on an absent beat");
    a_clear_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clear_latch_now |-> !o_out_data.present)
        else $error("clear request while present");
    a_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !advance |=> r_s1_valid && $stable(r_s1_data))
        else $error("held input beat lost");
`endif

endmodule

`default_nettype wire
